// ----- sv/sfhf_pkg.sv -----
// ----------------------------------------------------------------------------
// sfhf_pkg: shared types and constants of the stereo flanger
// Sequencer steps, the control bundle that drives both channel lanes, the
// configuration register set with its reset values and register indexes.
// ----------------------------------------------------------------------------
package sfhf_pkg;

    // The sine index takes the top bits of the phase; the quarter-wave fold
    // uses the two top bits of that index as the quadrant.
    localparam int SINE_ENTRIES = 256;
    localparam int SINE_BITS    = $clog2(SINE_ENTRIES);

    // APB address width: six registers at byte spacing of four.
    localparam int CFG_ADDR_BITS = 5;
    localparam int CFG_DATA_BITS = 32;

    // Register indexes (byte address divided by four).
    typedef enum logic [2:0] {
        REG_LFO_INCREMENT = 3'd0,
        REG_BASE_DELAY    = 3'd1,
        REG_DEPTH_DELAY   = 3'd2,
        REG_FEEDBACK_GAIN = 3'd3,
        REG_HP_COEF       = 3'd4,
        REG_MIX_LEVEL     = 3'd5
    } cfg_reg_t;

    // Register values after reset.
    localparam logic [23:0] RST_LFO_INCREMENT = 24'd49214;
    localparam logic [15:0] RST_BASE_DELAY    = 16'd1216;
    localparam logic [15:0] RST_DEPTH_DELAY   = 16'd4480;
    localparam logic [15:0] RST_FEEDBACK_GAIN = 16'd26214;
    localparam logic [15:0] RST_HP_COEF       = 16'd1024;
    localparam logic [16:0] RST_MIX_LEVEL     = 17'd39322;

    // Configuration seen by the lanes.
    typedef struct packed {
        logic [23:0] lfo_increment;
        logic [15:0] base_delay;
        logic [15:0] depth_delay;
        logic [15:0] feedback_gain;
        logic [15:0] hp_coef;
        logic [16:0] mix_level;
    } cfg_t;

    // Steps of the per-beat sequence, shared by both lanes.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_POLY,
        ST_SINE,
        ST_DEPTH,
        ST_ADDR,
        ST_READ,
        ST_INTERP,
        ST_HPMUL,
        ST_HPADD,
        ST_GAIN,
        ST_FINISH
    } step_t;

    // Control bundle from the sequencer to the lanes.
    typedef struct packed {
        step_t      step;
        logic       load;
        logic [1:0] poly_idx;
        logic       commit;
    } ctrl_t;

endpackage

// ----- sv/sfhf_lane.sv -----
// ----------------------------------------------------------------------------
// sfhf_lane: one flanger channel
// Holds the channel's delay line, LFO phase and high-pass state, and works one
// sample through sine polynomial, delay, interpolated read, high-pass, line write
// and dry/wet mix under the shared sequencer.
// ----------------------------------------------------------------------------
module sfhf_lane #(
    parameter int LINE_DEPTH    = 1024,
    parameter int SAMPLE_BITS   = 24,
    parameter int PHASE_BITS    = 32,
    parameter bit START_QUARTER = 1'b0
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  sfhf_pkg::ctrl_t                             ctrl,
    input  sfhf_pkg::cfg_t                              cfg,
    input  logic [$clog2(LINE_DEPTH)-1:0]               wr_idx,
    input  logic [$clog2(LINE_DEPTH+1)-1:0]             fill,
    input  logic signed [SAMPLE_BITS-1:0]               x_in,
    output logic signed [SAMPLE_BITS-1:0]               y_out
);
    import sfhf_pkg::*;

    localparam int AW  = $clog2(LINE_DEPTH);
    localparam int FW  = $clog2(LINE_DEPTH + 1);
    localparam int RW  = (AW + 7 > 18) ? AW + 7 : 18;
    localparam int SB  = SAMPLE_BITS;
    localparam int HW  = SB + 1;
    localparam int IW  = SB + 9;
    localparam int LW  = SB + 18;
    localparam int YW  = SB + 20;
    localparam int SW  = SB + 4;
    localparam int FRAC_SHIFT = 16 - (SINE_BITS - 2);

    localparam logic [RW-1:0] SPAN     = RW'(LINE_DEPTH * 64);
    localparam logic [RW-1:0] SPAN_MAX = RW'(LINE_DEPTH * 64 - 1);
    localparam logic [AW-1:0] IDX_LAST = AW'(LINE_DEPTH - 1);

    localparam logic signed [SW-1:0] SAT_HI = {{(SW-SB+1){1'b0}}, {(SB-1){1'b1}}};
    localparam logic signed [SW-1:0] SAT_LO = {{(SW-SB+1){1'b1}}, {(SB-1){1'b0}}};

    localparam logic [PHASE_BITS-1:0] PHASE_INIT =
        START_QUARTER ? {2'b01, {(PHASE_BITS-2){1'b0}}} : '0;

    // Clamp to the sample range.
    function automatic logic signed [SB-1:0] sat_fn(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] c;
        c = (v > SAT_HI) ? SAT_HI : ((v < SAT_LO) ? SAT_LO : v);
        return c[SB-1:0];
    endfunction

    // Horner coefficients of the odd sine polynomial, innermost first.
    function automatic logic [16:0] horner_coef(input logic [1:0] idx);
        logic [16:0] c;
        case (idx)
            2'd0:    c = 17'd307;
            2'd1:    c = 17'd5223;
            2'd2:    c = 17'd42334;
            2'd3:    c = 17'd102944;
            default: c = 17'd0;
        endcase
        return c;
    endfunction

    // Storage.
    logic signed [SB-1:0] line_mem [LINE_DEPTH];
    logic signed [SB-1:0] rd0_reg, rd1_reg;
    logic [PHASE_BITS-1:0] phase_reg;
    logic signed [SB-1:0] z_reg;
    logic signed [SB-1:0] x_reg;
    logic [16:0]          a2_reg;
    logic [16:0]          r_reg;
    logic signed [17:0]   s_reg;
    logic [32:0]          dprod_reg;
    logic [RW-1:0]        d_reg;
    logic [5:0]           f_reg;
    logic                 v0_reg, v1_reg;
    logic signed [SB-1:0] wet_reg;
    logic signed [LW-1:0] lprod_reg;
    logic signed [HW-1:0] hp_reg;
    logic signed [LW-1:0] fbp_reg;
    logic signed [YW-1:0] dryp_reg;
    logic signed [YW-1:0] wetp_reg;

    // Quarter-wave fold of the sine index taken from the phase.
    logic [SINE_BITS-1:0] k_idx;
    logic [1:0]           quad;
    logic [15:0]          frac;
    logic [16:0]          a_val;
    logic [33:0]          sq_prod;
    logic [33:0]          poly_prod;
    logic [16:0]          r_next;
    logic [33:0]          sine_prod;
    logic [16:0]          mag;
    logic signed [17:0]   s_next;

    always_comb begin
        k_idx     = phase_reg[PHASE_BITS-1 -: SINE_BITS];
        quad      = k_idx[SINE_BITS-1 -: 2];
        frac      = 16'(k_idx[SINE_BITS-3:0]) << FRAC_SHIFT;
        a_val     = quad[0] ? (17'd65536 - {1'b0, frac}) : {1'b0, frac};
        sq_prod   = 34'(a_val) * 34'(a_val);
        poly_prod = 34'(a2_reg) * 34'(r_reg);
        r_next    = horner_coef(ctrl.poly_idx) - poly_prod[32:16];
        sine_prod = 34'(a_val) * 34'(r_reg);
        mag       = (sine_prod[33:16] > 18'd65536) ? 17'd65536 : sine_prod[32:16];
        s_next    = quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end

    // Delay from the sine, then the read position behind the write pointer.
    logic signed [17:0] h_sum;
    logic [16:0]        h_val;
    logic [RW-1:0]      d_sum;
    logic [RW-1:0]      d_next;
    logic [RW-1:0]      r_sum;
    logic [RW-1:0]      r_pos;
    logic [AW-1:0]      i0_idx, i1_idx;

    always_comb begin
        h_sum  = s_reg + 18'sd65536;
        h_val  = h_sum[17:1];
        d_sum  = RW'(cfg.base_delay) + RW'(dprod_reg[32:16]);
        d_next = (d_sum > SPAN_MAX) ? SPAN_MAX : d_sum;
        r_sum  = RW'({wr_idx, 6'b0}) + SPAN - d_reg;
        r_pos  = (r_sum >= SPAN) ? (r_sum - SPAN) : r_sum;
        i0_idx = r_pos[AW+5:6];
        i1_idx = (i0_idx == IDX_LAST) ? '0 : (i0_idx + AW'(1));
    end

    // Interpolation, high-pass, feedback and mix arithmetic.
    logic signed [SB-1:0] l0_val, l1_val;
    logic signed [IW-1:0] ip_sum;
    logic signed [IW-1:0] ip_shift;
    logic signed [HW-1:0] hp_diff;
    logic signed [LW-1:0] lp_shift;
    logic signed [HW-1:0] z_sum;
    logic signed [SB-1:0] z_next;
    logic signed [HW-1:0] hp_next;
    logic [16:0]          dry_gain;
    logic signed [LW-1:0] fb_shift;
    logic signed [SW-1:0] line_sum;
    logic signed [SB-1:0] line_wr;
    logic signed [YW-1:0] mix_sum;
    logic signed [YW-1:0] mix_shift;

    always_comb begin
        l0_val   = v0_reg ? rd0_reg : '0;
        l1_val   = v1_reg ? rd1_reg : '0;
        ip_sum   = IW'(l0_val) * IW'($signed({1'b0, 7'd64 - 7'(f_reg)}))
                 + IW'(l1_val) * IW'($signed({1'b0, f_reg}));
        ip_shift = ip_sum >>> 6;
        hp_diff  = HW'(wet_reg) - HW'(z_reg);
        lp_shift = lprod_reg >>> 16;
        z_sum    = HW'(z_reg) + lp_shift[HW-1:0];
        z_next   = z_sum[SB-1:0];
        hp_next  = HW'(wet_reg) - HW'(z_next);
        dry_gain = 17'd65536 - 17'(cfg.mix_level >> 1);
        fb_shift = fbp_reg >>> 16;
        line_sum = SW'(x_reg) + fb_shift[SW-1:0];
        line_wr  = sat_fn(line_sum);
        mix_sum  = dryp_reg + wetp_reg;
        mix_shift = mix_sum >>> 16;
        y_out    = sat_fn(mix_shift[SW-1:0]);
    end

    // Datapath registers, each loaded in its own step.
    always_ff @(posedge aclk) begin
        case (ctrl.step)
            ST_IDLE: begin
                if (ctrl.load) begin
                    x_reg  <= x_in;
                    a2_reg <= sq_prod[32:16];
                    r_reg  <= 17'd11;
                end
            end
            ST_POLY: begin
                r_reg <= r_next;
            end
            ST_SINE: begin
                s_reg <= s_next;
            end
            ST_DEPTH: begin
                dprod_reg <= 33'(cfg.depth_delay) * 33'(h_val);
            end
            ST_ADDR: begin
                d_reg <= d_next;
            end
            ST_READ: begin
                f_reg  <= r_pos[5:0];
                v0_reg <= FW'(i0_idx) < fill;
                v1_reg <= FW'(i1_idx) < fill;
            end
            ST_INTERP: begin
                wet_reg <= ip_shift[SB-1:0];
            end
            ST_HPMUL: begin
                lprod_reg <= LW'($signed({1'b0, cfg.hp_coef})) * LW'(hp_diff);
            end
            ST_HPADD: begin
                hp_reg <= hp_next;
            end
            ST_GAIN: begin
                fbp_reg  <= LW'($signed({1'b0, cfg.feedback_gain})) * LW'(hp_reg);
                dryp_reg <= YW'(x_reg) * YW'($signed({1'b0, dry_gain}));
                wetp_reg <= YW'(hp_reg) * YW'($signed({1'b0, cfg.mix_level}));
            end
            default: begin
            end
        endcase
    end

    // Channel state: LFO phase and low-pass accumulator.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PHASE_INIT;
            z_reg     <= '0;
        end else begin
            if (ctrl.step == ST_HPADD) begin
                z_reg <= z_next;
            end
            if (ctrl.commit) begin
                phase_reg <= phase_reg + PHASE_BITS'(cfg.lfo_increment);
            end
        end
    end

    // Delay line: two registered reads, one write at the shared pointer.
    always_ff @(posedge aclk) begin
        if (ctrl.commit) begin
            line_mem[wr_idx] <= line_wr;
        end
        if (ctrl.step == ST_READ) begin
            rd0_reg <= line_mem[i0_idx];
            rd1_reg <= line_mem[i1_idx];
        end
    end

endmodule

// ----- sv/sfhf_merge.sv -----
// ----------------------------------------------------------------------------
// sfhf_merge: output stage
// Joins the left and right lane results into one output beat and holds it
// until it is taken, so the lanes can start on the next pair meanwhile.
// ----------------------------------------------------------------------------
module sfhf_merge #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          load,
    input  logic signed [SAMPLE_BITS-1:0] left_y,
    input  logic signed [SAMPLE_BITS-1:0] right_y,
    output logic                          slot_free,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_left_out,
    output logic signed [SAMPLE_BITS-1:0] m_right_out
);
    import sfhf_pkg::*;

    logic                          valid_reg;
    logic signed [SAMPLE_BITS-1:0] left_reg, right_reg;

    // The slot can take a new pair when empty or when its beat leaves now.
    assign slot_free   = !valid_reg || m_ready;
    assign m_valid     = valid_reg;
    assign m_left_out  = left_reg;
    assign m_right_out = right_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge aclk) begin
        if (load) begin
            left_reg  <= left_y;
            right_reg <= right_y;
        end
    end

endmodule

// ----- sv/stereo_flanger_highpass_feedback_top.sv -----
// ----------------------------------------------------------------------------
// stereo_flanger_highpass_feedback_top: stereo flanger with high-passed feedback
// Two channel lanes run side by side under one sequencer, sharing the write
// pointer and fill count; the output stage merges their results per beat.
//
//   Channel   Direction  Handshake            Payload
//   s_        in         s_valid / s_ready    s_left_in, s_right_in
//   m_        out        m_valid / m_ready    m_left_out, m_right_out
//   APB       in         psel/penable/pready  paddr, pwdata, prdata
//
// A beat runs under the shared sequencer from acceptance to the next
// acceptance: four Horner steps of the sine polynomial, then one
// registered step each for sine, delay, address, line read, interpolation,
// two high-pass steps, gains and the write-back.
// The write-back waits while the output stage still holds an untaken beat.
// Reset is synchronous and active low, and s_ready stays low while it is held;
// the delay lines are not cleared, a fill count marks entries not yet written,
// and those read as zero.
// ----------------------------------------------------------------------------
module stereo_flanger_highpass_feedback_top #(
    parameter int LINE_DEPTH  = 1024,
    parameter int SAMPLE_BITS = 24,
    parameter int PHASE_BITS  = 32
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    // Input channel
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic signed [SAMPLE_BITS-1:0]           s_left_in,
    input  logic signed [SAMPLE_BITS-1:0]           s_right_in,
    // Result channel
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic signed [SAMPLE_BITS-1:0]           m_left_out,
    output logic signed [SAMPLE_BITS-1:0]           m_right_out,
    // Configuration port
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [sfhf_pkg::CFG_ADDR_BITS-1:0]      paddr,
    input  logic [sfhf_pkg::CFG_DATA_BITS-1:0]      pwdata,
    output logic [sfhf_pkg::CFG_DATA_BITS-1:0]      prdata,
    output logic                                    pready
);
    import sfhf_pkg::*;

    localparam int AW = $clog2(LINE_DEPTH);
    localparam int FW = $clog2(LINE_DEPTH + 1);
    localparam logic [AW-1:0] IDX_LAST  = AW'(LINE_DEPTH - 1);
    localparam logic [FW-1:0] FILL_FULL = FW'(LINE_DEPTH);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    cfg_t     cfg_reg;
    cfg_reg_t reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = cfg_reg_t'(paddr[CFG_ADDR_BITS-1:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.lfo_increment <= RST_LFO_INCREMENT;
            cfg_reg.base_delay    <= RST_BASE_DELAY;
            cfg_reg.depth_delay   <= RST_DEPTH_DELAY;
            cfg_reg.feedback_gain <= RST_FEEDBACK_GAIN;
            cfg_reg.hp_coef       <= RST_HP_COEF;
            cfg_reg.mix_level     <= RST_MIX_LEVEL;
        end else if (psel && penable && pwrite && pready) begin
            case (reg_sel)
                REG_LFO_INCREMENT: cfg_reg.lfo_increment <= pwdata[23:0];
                REG_BASE_DELAY:    cfg_reg.base_delay    <= pwdata[15:0];
                REG_DEPTH_DELAY:   cfg_reg.depth_delay   <= pwdata[15:0];
                REG_FEEDBACK_GAIN: cfg_reg.feedback_gain <= pwdata[15:0];
                REG_HP_COEF:       cfg_reg.hp_coef       <= pwdata[15:0];
                REG_MIX_LEVEL:     cfg_reg.mix_level     <= pwdata[16:0];
                default: begin
                end
            endcase
        end
    end

    // Read-back of the register set.
    always_comb begin
        case (reg_sel)
            REG_LFO_INCREMENT: prdata = 32'(cfg_reg.lfo_increment);
            REG_BASE_DELAY:    prdata = 32'(cfg_reg.base_delay);
            REG_DEPTH_DELAY:   prdata = 32'(cfg_reg.depth_delay);
            REG_FEEDBACK_GAIN: prdata = 32'(cfg_reg.feedback_gain);
            REG_HP_COEF:       prdata = 32'(cfg_reg.hp_coef);
            REG_MIX_LEVEL:     prdata = 32'(cfg_reg.mix_level);
            default:           prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    step_t      state_reg, state_next;
    logic [1:0] poly_reg, poly_next;
    ctrl_t      ctrl;
    logic       slot_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            poly_reg  <= 2'd0;
        end else begin
            state_reg <= state_next;
            poly_reg  <= poly_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        poly_next     = poly_reg;
        s_ready       = 1'b0;
        ctrl.step     = state_reg;
        ctrl.load     = 1'b0;
        ctrl.poly_idx = poly_reg;
        ctrl.commit   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                // No beat is taken while reset is held.
                s_ready = aresetn;
                if (s_valid && aresetn) begin
                    ctrl.load  = 1'b1;
                    poly_next  = 2'd0;
                    state_next = ST_POLY;
                end
            end
            ST_POLY: begin
                poly_next = poly_reg + 2'd1;
                if (poly_reg == 2'd3) begin
                    state_next = ST_SINE;
                end
            end
            ST_SINE:   state_next = ST_DEPTH;
            ST_DEPTH:  state_next = ST_ADDR;
            ST_ADDR:   state_next = ST_READ;
            ST_READ:   state_next = ST_INTERP;
            ST_INTERP: state_next = ST_HPMUL;
            ST_HPMUL:  state_next = ST_HPADD;
            ST_HPADD:  state_next = ST_GAIN;
            ST_GAIN:   state_next = ST_FINISH;
            ST_FINISH: begin
                // Write back and hand over once the output stage has room.
                if (slot_free) begin
                    ctrl.commit = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Shared write pointer and fill count
    // ------------------------------------------------------------------
    logic [AW-1:0] wr_idx_reg;
    logic [FW-1:0] fill_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_idx_reg <= '0;
            fill_reg   <= '0;
        end else if (ctrl.commit) begin
            wr_idx_reg <= (wr_idx_reg == IDX_LAST) ? '0 : (wr_idx_reg + AW'(1));
            if (fill_reg != FILL_FULL) begin
                fill_reg <= fill_reg + FW'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Channel lanes and output stage
    // ------------------------------------------------------------------
    logic signed [SAMPLE_BITS-1:0] left_y, right_y;

    sfhf_lane #(
        .LINE_DEPTH    (LINE_DEPTH),
        .SAMPLE_BITS   (SAMPLE_BITS),
        .PHASE_BITS    (PHASE_BITS),
        .START_QUARTER (1'b0)
    ) u_lane_left (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .cfg     (cfg_reg),
        .wr_idx  (wr_idx_reg),
        .fill    (fill_reg),
        .x_in    (s_left_in),
        .y_out   (left_y)
    );

    sfhf_lane #(
        .LINE_DEPTH    (LINE_DEPTH),
        .SAMPLE_BITS   (SAMPLE_BITS),
        .PHASE_BITS    (PHASE_BITS),
        .START_QUARTER (1'b1)
    ) u_lane_right (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .cfg     (cfg_reg),
        .wr_idx  (wr_idx_reg),
        .fill    (fill_reg),
        .x_in    (s_right_in),
        .y_out   (right_y)
    );

    sfhf_merge #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_merge (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (ctrl.commit),
        .left_y      (left_y),
        .right_y     (right_y),
        .slot_free   (slot_free),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_left_out  (m_left_out),
        .m_right_out (m_right_out)
    );

endmodule
